### hdl/hvt_pkg.sv
package hvt_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int QBITS     = DATA_W;
  localparam int LO_W      = QBITS - FRAC_BITS;

  // configuration registers
  localparam int NCFG      = 8;
  localparam int CFG_SEL_W = $clog2(NCFG);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 64;
  localparam int NLANE     = 3;

  // pipeline: input, products, sums, magnitudes, setup, divide steps, output
  localparam int NDIV = QBITS;
  localparam int NSTG = NDIV + 6;

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << DATA_W;

  // identity matrix after reset
  function automatic logic [CFG_W-1:0] cfg_reset(input int idx);
    logic [CFG_W-1:0] r;
    r = '0;
    if (idx == 0 || idx == 5) r = ONE_LO;
    if (idx == 2 || idx == 7) r = ONE_HI;
    return r;
  endfunction

  // one component on its way through the divider
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QBITS-1:0] q;
    logic [LO_W-1:0]  lo;
    logic             neg;
    logic             big;
  } lane_t;

endpackage

### hdl/hvt_div_step.sv
module hvt_div_step (
  input  hvt_pkg::lane_t                lane_i,
  input  logic [hvt_pkg::MAG_W-1:0]     den_i,
  input  logic                          point_i,
  output hvt_pkg::lane_t                lane_o
);

  logic [hvt_pkg::MAG_W:0] r2;
  logic [hvt_pkg::MAG_W:0] diff;
  logic                    ge;

  // one restoring step when point_i is set: shift in next dividend bit, subtract if it fits; else pass through
  always_comb begin
    r2     = {lane_i.rem, lane_i.lo[hvt_pkg::LO_W-1]};
    diff   = r2 - {1'b0, den_i};
    ge     = (r2 >= {1'b0, den_i});
    lane_o = lane_i;
    if (point_i) begin
      lane_o.rem = ge ? diff[hvt_pkg::MAG_W-1:0] : r2[hvt_pkg::MAG_W-1:0];
      lane_o.q   = {lane_i.q[hvt_pkg::QBITS-2:0], ge};
      lane_o.lo  = {lane_i.lo[hvt_pkg::LO_W-2:0], 1'b0};
    end
  end

endmodule

### hdl/homogeneous_vertex_transform.sv
// throughput: one request per cycle while the output accepts results;
//   the divide is one quotient bit per stage, 32 stages, so every stage
//   holds its own request
// a stall at the output fills bubbles first, then holds the pipe without loss
// reset clears all valid bits and loads the identity matrix
module homogeneous_vertex_transform (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [hvt_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  req_type_i,
  input  logic signed [hvt_pkg::DATA_W-1:0]     in_x_i,
  input  logic signed [hvt_pkg::DATA_W-1:0]     in_y_i,
  input  logic signed [hvt_pkg::DATA_W-1:0]     in_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hvt_pkg::DATA_W-1:0]     out_x_o,
  output logic signed [hvt_pkg::DATA_W-1:0]     out_y_o,
  output logic signed [hvt_pkg::DATA_W-1:0]     out_z_o,
  output logic                                  w_was_zero_o,
  output logic                                  clipped_o
);

  localparam int NS = hvt_pkg::NSTG;
  localparam int ND = hvt_pkg::NDIV;
  localparam int NL = hvt_pkg::NLANE;
  localparam int DW = hvt_pkg::DATA_W;
  localparam int FB = hvt_pkg::FRAC_BITS;
  localparam int MW = hvt_pkg::MAG_W;
  localparam int SW = hvt_pkg::SUM_W;
  localparam int QB = hvt_pkg::QBITS;
  localparam int LW = hvt_pkg::LO_W;

  // ---------------- configuration ----------------
  logic [hvt_pkg::CFG_W-1:0] cfg_q [hvt_pkg::NCFG];
  logic signed [DW-1:0]      m [4][4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hvt_pkg::NCFG; i++) cfg_q[i] <= hvt_pkg::cfg_reset(i);
    end else if (cfg_valid_i && cfg_index_i < hvt_pkg::CFG_IDX_W'(hvt_pkg::NCFG)) begin
      cfg_q[cfg_index_i[hvt_pkg::CFG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // matrix entries, two per register
  always_comb begin
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        m[r][c] = cfg_q[r*2 + c/2][(c%2)*DW +: DW];
  end

  // ---------------- flow control ----------------
  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS] = out_ready_i;
    for (int i = NS-1; i >= 0; i--) en[i] = ~v_q[i] | en[i+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NS; i++)
        if (en[i]) v_q[i] <= v_q[i-1];
    end
  end

  // ---------------- stage 0: input request ----------------
  logic signed [DW-1:0] x0_q [NL];
  logic                 pt0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q[0] <= in_x_i;
      x0_q[1] <= in_y_i;
      x0_q[2] <= in_z_i;
      pt0_q   <= ~req_type_i;
    end
  end

  // ---------------- stage 1: products ----------------
  logic signed [MW-1:0] prod_q [4][NL];
  logic                 pt1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < NL; r++)
          prod_q[c][r] <= x0_q[r] * m[r][c];
      pt1_q <= pt0_q;
    end
  end

  // ---------------- stage 2: column sums ----------------
  logic signed [DW+FB-1:0] bias [4];
  logic signed [SW-1:0]    sum_q [4];
  logic                    pt2_q;

  // translation aligned to the product scale, point requests only
  always_comb begin
    for (int c = 0; c < 4; c++)
      bias[c] = pt1_q ? {m[3][c], FB'(0)} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < 4; c++)
        sum_q[c] <= SW'(prod_q[c][0]) + SW'(prod_q[c][1]) + SW'(prod_q[c][2])
                  + SW'(bias[c]);
      pt2_q <= pt1_q;
    end
  end

  // ---------------- stage 3: sign and magnitude ----------------
  logic [MW-1:0] mag_q [4];
  logic          neg3_q [4];
  logic          pt3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < 4; c++) begin
        neg3_q[c] <= sum_q[c][SW-1];
        mag_q[c]  <= sum_q[c][SW-1] ? MW'(-sum_q[c]) : sum_q[c][MW-1:0];
      end
      pt3_q <= pt2_q;
    end
  end

  // ---------------- stage 4: divider setup or direction rounding ----------------
  hvt_pkg::lane_t       div_q  [ND+1][NL];
  hvt_pkg::lane_t       step_d [ND][NL];
  hvt_pkg::lane_t       lane_d [NL];
  logic [MW-1:0]        den_q  [ND+1];
  logic                 dpt_q  [ND+1];
  logic                 dwz_q  [ND+1];
  logic [SW-1:0]        rnd [NL];

  localparam logic [SW-1:0] HALF = SW'(1) << (FB-1);

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rnd[l]    = {1'b0, mag_q[l]} + HALF;
      lane_d[l] = '0;
      if (pt3_q) begin
        lane_d[l].neg = neg3_q[l] ^ neg3_q[3];
        lane_d[l].big = {LW'(0), mag_q[l]} >= {mag_q[3], LW'(0)};
        lane_d[l].rem = MW'(mag_q[l] >> LW);
        lane_d[l].lo  = mag_q[l][LW-1:0];
      end else begin
        lane_d[l].neg = neg3_q[l];
        lane_d[l].big = |rnd[l][SW-1:FB+QB];
        lane_d[l].q   = rnd[l][FB+QB-1:FB];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      div_q[0] <= lane_d;
      den_q[0] <= mag_q[3];
      dpt_q[0] <= pt3_q;
      dwz_q[0] <= pt3_q & (mag_q[3] == '0);
    end
  end

  // ---------------- stages 5 onward: one quotient bit per stage ----------------
  for (genvar k = 0; k < ND; k++) begin : g_div
    for (genvar l = 0; l < NL; l++) begin : g_lane
      hvt_div_step u_step (
        .lane_i  (div_q[k][l]),
        .den_i   (den_q[k]),
        .point_i (dpt_q[k] & ~dwz_q[k]),
        .lane_o  (step_d[k][l])
      );
    end

    always_ff @(posedge clk_i) begin
      if (en[5+k]) begin
        div_q[k+1] <= step_d[k];
        den_q[k+1] <= den_q[k];
        dpt_q[k+1] <= dpt_q[k];
        dwz_q[k+1] <= dwz_q[k];
      end
    end
  end

  // ---------------- last stage: round, saturate ----------------
  logic                 inc  [NL];
  logic [QB:0]          mag33 [NL];
  logic                 clip [NL];
  logic signed [DW-1:0] res  [NL];
  logic signed [DW-1:0] out_q [NL];
  logic                 wz_q;
  logic                 clip_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      inc[l]   = dpt_q[ND] & ({div_q[ND][l].rem, 1'b0} >= {1'b0, den_q[ND]});
      mag33[l] = {1'b0, div_q[ND][l].q} + (QB+1)'(inc[l]);
      if (dwz_q[ND]) begin
        clip[l] = 1'b0;
        res[l]  = '0;
      end else if (!div_q[ND][l].neg) begin
        clip[l] = div_q[ND][l].big | (mag33[l] > {2'b00, {(QB-1){1'b1}}});
        res[l]  = clip[l] ? {1'b0, {(DW-1){1'b1}}} : mag33[l][DW-1:0];
      end else begin
        clip[l] = div_q[ND][l].big | (mag33[l] > {2'b01, {(QB-1){1'b0}}});
        res[l]  = clip[l] ? {1'b1, {(DW-1){1'b0}}} : (~mag33[l][DW-1:0] + DW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q  <= res;
      wz_q   <= dwz_q[ND];
      clip_q <= clip[0] | clip[1] | clip[2];
    end
  end

  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign w_was_zero_o = wz_q;
  assign clipped_o    = clip_q;

endmodule
